// ----- rtl/assert_macros.svh -----
// shared assertion macros for the rotation block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rpa_pkg.sv -----
package rpa_pkg;

    // default formats: coordinates Q16.16, direction and trig Q2.16
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_ORIGIN_Z,
        REG_AXIS_X,
        REG_AXIS_Y,
        REG_AXIS_Z,
        REG_COS,
        REG_SIN
    } t_reg_idx;

    // width of the configuration data bus
    function automatic int cfg_data_w(input int coord_w, input int frac_b);
        int trig_w;
        trig_w = frac_b + 2;
        return (coord_w > trig_w) ? coord_w : trig_w;
    endfunction

endpackage

// ----- rtl/rpa_if.sv -----
// input point channel
interface rpa_pt_if #(
    parameter int W = rpa_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] point_x;
    logic signed [W-1:0] point_y;
    logic signed [W-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

// rotated point channel
interface rpa_res_if #(
    parameter int W = rpa_pkg::COORD_WIDTH_DEF
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] rotated_x;
    logic signed [W-1:0] rotated_y;
    logic signed [W-1:0] rotated_z;
    logic                overflow;

    modport source (output valid, output rotated_x, output rotated_y,
                    output rotated_z, output overflow, input ready);
    modport sink   (input valid, input rotated_x, input rotated_y,
                    input rotated_z, input overflow, output ready);
endinterface

// configuration write channel
interface rpa_cfg_if #(
    parameter int DATA_W = rpa_pkg::cfg_data_w(rpa_pkg::COORD_WIDTH_DEF,
                                                rpa_pkg::FRAC_BITS_DEF)
);
    logic                          valid;
    logic                          ready;
    logic [rpa_pkg::CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]             data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rpa_cfg.sv -----
module rpa_cfg #(
    parameter int COORD_WIDTH = rpa_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rpa_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rpa_cfg_if.sink                       i_cfg,
    output logic signed [COORD_WIDTH-1:0] o_org  [3],
    output logic signed [FRAC_BITS+1:0]   o_kdir [3],
    output logic signed [FRAC_BITS+1:0]   o_cos,
    output logic signed [FRAC_BITS+1:0]   o_sin
);
    localparam int W   = COORD_WIDTH;
    localparam int T   = FRAC_BITS + 2;
    localparam int ONE = 1 << FRAC_BITS;

    logic signed [W-1:0] r_org  [3];
    logic signed [T-1:0] r_kdir [3];
    logic signed [T-1:0] r_cos;
    logic signed [T-1:0] r_sin;
    logic                wr;

    // writes are always taken
    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid;

    // register file, reset to rotation by zero about z through the origin
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0]  <= '0;
            r_org[1]  <= '0;
            r_org[2]  <= '0;
            r_kdir[0] <= '0;
            r_kdir[1] <= '0;
            r_kdir[2] <= T'(ONE);
            r_cos     <= T'(ONE);
            r_sin     <= '0;
        end else if (wr) begin
            unique case (rpa_pkg::t_reg_idx'(i_cfg.index))
                rpa_pkg::REG_ORIGIN_X: r_org[0]  <= i_cfg.data[W-1:0];
                rpa_pkg::REG_ORIGIN_Y: r_org[1]  <= i_cfg.data[W-1:0];
                rpa_pkg::REG_ORIGIN_Z: r_org[2]  <= i_cfg.data[W-1:0];
                rpa_pkg::REG_AXIS_X:   r_kdir[0] <= i_cfg.data[T-1:0];
                rpa_pkg::REG_AXIS_Y:   r_kdir[1] <= i_cfg.data[T-1:0];
                rpa_pkg::REG_AXIS_Z:   r_kdir[2] <= i_cfg.data[T-1:0];
                rpa_pkg::REG_COS:      r_cos     <= i_cfg.data[T-1:0];
                rpa_pkg::REG_SIN:      r_sin     <= i_cfg.data[T-1:0];
            endcase
        end
    end

    assign o_org  = r_org;
    assign o_kdir = r_kdir;
    assign o_cos  = r_cos;
    assign o_sin  = r_sin;

endmodule

// ----- rtl/rpa_pipe.sv -----
`include "assert_macros.svh"

module rpa_pipe #(
    parameter int COORD_WIDTH = rpa_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rpa_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic signed [COORD_WIDTH-1:0] i_org  [3],
    input  logic signed [FRAC_BITS+1:0]   i_kdir [3],
    input  logic signed [FRAC_BITS+1:0]   i_cos,
    input  logic signed [FRAC_BITS+1:0]   i_sin,
    rpa_pt_if.sink                        i_pt,
    rpa_res_if.source                     o_res
);
    localparam int W    = COORD_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int T    = F + 2;
    localparam int VW   = W + 1;          // p - o
    localparam int PW   = VW + T;         // k * v
    localparam int CSW  = PW + 2;         // cross sum with rounding
    localparam int CW   = CSW - F;        // c
    localparam int DSW  = PW + 3;         // dot sum with rounding
    localparam int DW   = DSW - F;        // d
    localparam int KW   = DW + T;         // k * d
    localparam int TSW  = KW + 1;
    localparam int TW   = TSW - F;        // t
    localparam int MW   = T + 1;          // 1 - cos
    localparam int VCW  = VW + T;         // v * cos
    localparam int CSPW = CW + T;         // c * sin
    localparam int TMW  = TW + MW;        // t * m
    localparam int SW   = TMW + 2;        // partial result sum
    localparam int RSW  = SW + 1;
    localparam int RW   = RSW - F;        // r
    localparam int OW   = RW + 1;         // o + r
    localparam int NS   = 8;
    localparam int HALF = 1 << (F - 1);
    localparam int ONE  = 1 << F;

    localparam logic signed [W-1:0] MAX_W = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    logic [NS-1:0] r_vld;
    logic [NS-1:0] en;

    // stage 0: shift to axis origin
    logic signed [VW-1:0]   n_v0 [3], r_v0 [3];
    // stage 1: direction times offset
    logic signed [PW-1:0]   n_pa [3], r_pa [3];
    logic signed [PW-1:0]   n_pb [3], r_pb [3];
    logic signed [PW-1:0]   n_pd [3], r_pd [3];
    logic signed [VW-1:0]   r_v1 [3];
    // stage 2: cross product and dot product
    logic signed [CW-1:0]   n_c  [3], r_c  [3];
    logic signed [DW-1:0]   n_d, r_d;
    logic signed [VW-1:0]   r_v2 [3];
    // stage 3: trig products and k * d
    logic signed [VCW-1:0]  n_vc [3], r_vc [3];
    logic signed [CSPW-1:0] n_cs [3], r_cs [3];
    logic signed [KW-1:0]   n_kd [3], r_kd [3];
    // stage 4: t and partial sum
    logic signed [TW-1:0]   n_t  [3], r_t  [3];
    logic signed [SW-1:0]   n_s4 [3], r_s4 [3];
    // stage 5: t * (1 - cos)
    logic signed [MW-1:0]   m;
    logic signed [TMW-1:0]  n_tm [3], r_tm [3];
    logic signed [SW-1:0]   r_s5 [3];
    // stage 6: rounded rotation
    logic signed [RW-1:0]   n_r  [3], r_r  [3];
    // stage 7: origin back, saturate
    logic signed [OW-1:0]   n_sum [3];
    logic signed [W-1:0]    n_o  [3], r_o  [3];
    logic                   n_ovf, r_ovf;

    // per-stage advance: a stage loads when it is empty or its successor loads
    always_comb begin
        en[NS-1] = !r_vld[NS-1] || o_res.ready;
        for (int s = NS - 2; s >= 0; s--) begin
            en[s] = !r_vld[s] || en[s+1];
        end
    end

    assign i_pt.ready = en[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pt.valid;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // stage 0 logic
    always_comb begin
        n_v0[0] = VW'(i_pt.point_x) - VW'(i_org[0]);
        n_v0[1] = VW'(i_pt.point_y) - VW'(i_org[1]);
        n_v0[2] = VW'(i_pt.point_z) - VW'(i_org[2]);
    end

    // stage 1 logic: cross terms a - b and dot terms
    always_comb begin
        n_pa[0] = PW'(i_kdir[1]) * PW'(r_v0[2]);
        n_pb[0] = PW'(i_kdir[2]) * PW'(r_v0[1]);
        n_pa[1] = PW'(i_kdir[2]) * PW'(r_v0[0]);
        n_pb[1] = PW'(i_kdir[0]) * PW'(r_v0[2]);
        n_pa[2] = PW'(i_kdir[0]) * PW'(r_v0[1]);
        n_pb[2] = PW'(i_kdir[1]) * PW'(r_v0[0]);
        for (int i = 0; i < 3; i++) begin
            n_pd[i] = PW'(i_kdir[i]) * PW'(r_v0[i]);
        end
    end

    // stage 2 logic: round cross and dot
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_c[i] = CW'((CSW'(r_pa[i]) - CSW'(r_pb[i]) + CSW'(HALF)) >>> F);
        end
        n_d = DW'((DSW'(r_pd[0]) + DSW'(r_pd[1]) + DSW'(r_pd[2]) + DSW'(HALF)) >>> F);
    end

    // stage 3 logic
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_vc[i] = VCW'(r_v2[i]) * VCW'(i_cos);
            n_cs[i] = CSPW'(r_c[i]) * CSPW'(i_sin);
            n_kd[i] = KW'(i_kdir[i]) * KW'(r_d);
        end
    end

    // stage 4 logic
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_t[i]  = TW'((TSW'(r_kd[i]) + TSW'(HALF)) >>> F);
            n_s4[i] = SW'(r_vc[i]) + SW'(r_cs[i]);
        end
    end

    // stage 5 logic
    assign m = MW'(ONE) - MW'(i_cos);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_tm[i] = TMW'(r_t[i]) * TMW'(m);
        end
    end

    // stage 6 logic
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_r[i] = RW'((RSW'(r_s5[i]) + RSW'(r_tm[i]) + RSW'(HALF)) >>> F);
        end
    end

    // stage 7 logic: add origin, clamp to coordinate range
    always_comb begin
        n_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_sum[i] = OW'(i_org[i]) + OW'(r_r[i]);
            if (n_sum[i] > OW'(MAX_W)) begin
                n_o[i] = MAX_W;
                n_ovf  = 1'b1;
            end else if (n_sum[i] < OW'(MIN_W)) begin
                n_o[i] = MIN_W;
                n_ovf  = 1'b1;
            end else begin
                n_o[i] = W'(n_sum[i]);
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_v0 <= n_v0;
        end
        if (en[1]) begin
            r_pa <= n_pa;
            r_pb <= n_pb;
            r_pd <= n_pd;
            r_v1 <= r_v0;
        end
        if (en[2]) begin
            r_c  <= n_c;
            r_d  <= n_d;
            r_v2 <= r_v1;
        end
        if (en[3]) begin
            r_vc <= n_vc;
            r_cs <= n_cs;
            r_kd <= n_kd;
        end
        if (en[4]) begin
            r_t  <= n_t;
            r_s4 <= n_s4;
        end
        if (en[5]) begin
            r_tm <= n_tm;
            r_s5 <= r_s4;
        end
        if (en[6]) begin
            r_r <= n_r;
        end
        if (en[7]) begin
            r_o   <= n_o;
            r_ovf <= n_ovf;
        end
    end

    // result
    assign o_res.valid     = r_vld[NS-1];
    assign o_res.rotated_x = r_o[0];
    assign o_res.rotated_y = r_o[1];
    assign o_res.rotated_z = r_o[2];
    assign o_res.overflow  = r_ovf;

    // input is refused only when every stage holds an item
    `ASSERT_IMPL(a_no_bubble_stall, i_clk, i_rst_n, !i_pt.ready, (&r_vld), "stall with a bubble in the pipe")

    // a stalled stage keeps its item
    `ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_vld[1] && !en[1], r_vld[1] && $stable(r_pd[0]) && $stable(r_v1[0]), "stalled stage lost its item")

    // overflow only with a clamped coordinate
    `ASSERT_IMPL(a_ovf_clamped, i_clk, i_rst_n, o_res.valid && o_res.overflow, r_o[0] == MAX_W || r_o[0] == MIN_W || r_o[1] == MAX_W || r_o[1] == MIN_W || r_o[2] == MAX_W || r_o[2] == MIN_W, "overflow without saturated coordinate")

endmodule

// ----- rtl/rotate_point_about_axis.sv -----
// channel   dir   handshake      payload
// i_cfg     in    valid/ready    index, data (register write)
// i_pt      in    valid/ready    point_x, point_y, point_z
// o_res     out   valid/ready    rotated_x, rotated_y, rotated_z, overflow
//
// one item per cycle sustained while o_res is ready; each item passes in order
// through offset, direction products, cross/dot rounding, trig products, t,
// t*(1-cos), final rounding, origin add and saturation
// reset clears all valid bits and loads the registers with a zero-angle
// rotation about z through the origin; config writes are always taken
// a stall at o_res holds the last stage; empty stages ahead still fill,
// so i_pt.ready drops only when all 8 stages hold an item
module rotate_point_about_axis #(
    parameter int COORD_WIDTH = rpa_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = rpa_pkg::FRAC_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rpa_cfg_if.sink   i_cfg,
    rpa_pt_if.sink    i_pt,
    rpa_res_if.source o_res
);
    logic signed [COORD_WIDTH-1:0] org  [3];
    logic signed [FRAC_BITS+1:0]   kdir [3];
    logic signed [FRAC_BITS+1:0]   cos_a;
    logic signed [FRAC_BITS+1:0]   sin_a;

    // configuration registers
    rpa_cfg #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_org   (org),
        .o_kdir  (kdir),
        .o_cos   (cos_a),
        .o_sin   (sin_a)
    );

    // rotation pipeline
    rpa_pipe #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_org   (org),
        .i_kdir  (kdir),
        .i_cos   (cos_a),
        .i_sin   (sin_a),
        .i_pt    (i_pt),
        .o_res   (o_res)
    );

endmodule

// ----- test/rotate_point_about_axis_tb.sv -----
`timescale 1ns / 1ps

module rotate_point_about_axis_tb;

    localparam int CW = rpa_pkg::COORD_WIDTH_DEF;
    localparam int FB = rpa_pkg::FRAC_BITS_DEF;
    localparam int TW = FB + 2;
    localparam int DW = rpa_pkg::cfg_data_w(CW, FB);
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 20;

    typedef logic signed [127:0] t_wide;
    typedef logic signed [CW-1:0] t_coord;
    typedef t_coord [2:0] t_vec3;
    typedef struct packed {
        t_vec3 rot;
        logic  overflow;
    } t_rot_result;

    localparam t_wide Q_ONE  = 128'sd1 <<< FB;
    localparam t_wide Q_HALF = 128'sd1 <<< (FB - 1);
    localparam t_coord COORD_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(CW-1){1'b0}}};

    // expected rotated points, predicted from the register copy
    class t_rotation_scoreboard;
        t_wide       org [3];
        t_wide       dir [3];
        t_wide       cos_q;
        t_wide       sin_q;
        t_rot_result expected_pts [$];
        string       field_name [3];
        int          errors;

        function new();
            org[0] = 0;
            org[1] = 0;
            org[2] = 0;
            dir[0] = 0;
            dir[1] = 0;
            dir[2] = Q_ONE;
            cos_q = Q_ONE;
            sin_q = 0;
            errors = 0;
            field_name[0] = "rotated_x";
            field_name[1] = "rotated_y";
            field_name[2] = "rotated_z";
        endfunction

        // divide by 2^F, ties toward plus infinity
        function t_wide round_q(t_wide x);
            return (x + Q_HALF) >>> FB;
        endfunction

        function void write_reg(rpa_pkg::t_reg_idx idx, logic [DW-1:0] data);
            case (idx)
                rpa_pkg::REG_ORIGIN_X, rpa_pkg::REG_ORIGIN_Y, rpa_pkg::REG_ORIGIN_Z: begin
                    org[int'(idx) - int'(rpa_pkg::REG_ORIGIN_X)] = $signed(data[CW-1:0]);
                end
                rpa_pkg::REG_AXIS_X, rpa_pkg::REG_AXIS_Y, rpa_pkg::REG_AXIS_Z: begin
                    dir[int'(idx) - int'(rpa_pkg::REG_AXIS_X)] = $signed(data[TW-1:0]);
                end
                rpa_pkg::REG_COS: cos_q = $signed(data[TW-1:0]);
                rpa_pkg::REG_SIN: sin_q = $signed(data[TW-1:0]);
                default: ;
            endcase
        endfunction

        function void note_point(t_vec3 p);
            t_wide       v [3];
            t_wide       c [3];
            t_wide       t [3];
            t_wide       d;
            t_wide       m;
            t_wide       r;
            t_wide       hi_lim;
            t_wide       lo_lim;
            t_rot_result e;
            hi_lim = COORD_MAX;
            lo_lim = COORD_MIN;
            e.overflow = 1'b0;
            for (int i = 0; i < 3; i++) begin
                v[i] = $signed(p[i]);
                v[i] = v[i] - org[i];
            end
            // cross product k x v and dot product k.v
            c[0] = round_q(dir[1] * v[2] - dir[2] * v[1]);
            c[1] = round_q(dir[2] * v[0] - dir[0] * v[2]);
            c[2] = round_q(dir[0] * v[1] - dir[1] * v[0]);
            d = round_q(v[0] * dir[0] + v[1] * dir[1] + v[2] * dir[2]);
            m = Q_ONE - cos_q;
            for (int i = 0; i < 3; i++) begin
                t[i] = round_q(d * dir[i]);
                r = org[i] + round_q(v[i] * cos_q + c[i] * sin_q + t[i] * m);
                // saturate to the coordinate range
                if (r > hi_lim) begin
                    r = hi_lim;
                    e.overflow = 1'b1;
                end else if (r < lo_lim) begin
                    r = lo_lim;
                    e.overflow = 1'b1;
                end
                e.rot[i] = r[CW-1:0];
            end
            expected_pts.push_back(e);
        endfunction

        function void check_result(t_rot_result got);
            t_rot_result e;
            if (expected_pts.size() == 0) begin
                $error("rotated point with no input pending: x %0d y %0d z %0d",
                       got.rot[0], got.rot[1], got.rot[2]);
                errors++;
                return;
            end
            e = expected_pts.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.rot[i] !== e.rot[i]) begin
                    $error("%s mismatch: expected %0d, got %0d",
                           field_name[i], e.rot[i], got.rot[i]);
                    errors++;
                end
            end
            if (got.overflow !== e.overflow) begin
                $error("overflow mismatch: expected %0d, got %0d", e.overflow, got.overflow);
                errors++;
            end
        endfunction

        function int pending();
            return expected_pts.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;
    int   quiet_cycles;

    t_rotation_scoreboard rot_sb;

    rpa_cfg_if cfg_if ();
    rpa_pt_if  pt_if ();
    rpa_res_if res_if ();

    rotate_point_about_axis DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pt    (pt_if),
        .o_res   (res_if)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side back-pressure
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watch all three channels, predict and check
    always @(posedge i_clk) begin : channel_mon
        t_rot_result got;
        t_vec3       pt;
        if (i_rst_n) begin
            if (cfg_if.valid && cfg_if.ready) begin
                rot_sb.write_reg(rpa_pkg::t_reg_idx'(cfg_if.index), cfg_if.data);
            end
            if (pt_if.valid && pt_if.ready) begin
                pt[0] = pt_if.point_x;
                pt[1] = pt_if.point_y;
                pt[2] = pt_if.point_z;
                rot_sb.note_point(pt);
            end
            if (res_if.valid && res_if.ready) begin
                got.rot[0] = res_if.rotated_x;
                got.rot[1] = res_if.rotated_y;
                got.rot[2] = res_if.rotated_z;
                got.overflow = res_if.overflow;
                rot_sb.check_result(got);
            end
        end
    end

    // watchdog on cycles where no channel moves anything
    always @(posedge i_clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic write_reg(input rpa_pkg::t_reg_idx idx, input logic [DW-1:0] data);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // load all eight registers back to back
    task automatic set_rotation(input logic [DW-1:0] ox, oy, oz, kx, ky, kz, cs, sn);
        write_reg(rpa_pkg::REG_ORIGIN_X, ox);
        write_reg(rpa_pkg::REG_ORIGIN_Y, oy);
        write_reg(rpa_pkg::REG_ORIGIN_Z, oz);
        write_reg(rpa_pkg::REG_AXIS_X, kx);
        write_reg(rpa_pkg::REG_AXIS_Y, ky);
        write_reg(rpa_pkg::REG_AXIS_Z, kz);
        write_reg(rpa_pkg::REG_COS, cs);
        write_reg(rpa_pkg::REG_SIN, sn);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_point(input t_coord x, y, z);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            pt_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_if.valid   <= 1'b1;
        pt_if.point_x <= x;
        pt_if.point_y <= y;
        pt_if.point_z <= z;
        do @(posedge i_clk); while (!pt_if.ready);
    endtask

    // stop sending and let every rotated point come back
    task automatic wait_for_results();
        @(negedge i_clk);
        pt_if.valid <= 1'b0;
        while (rot_sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic t_coord rand_coord();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            2: begin
                case ($urandom_range(3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom_range(32'h0FFF_FFFF) - 32'h0800_0000;
        endcase
    endfunction

    // trig and direction values: mostly in range, some raw bit patterns
    function automatic logic [DW-1:0] rand_trig();
        case ($urandom_range(3))
            0: return $urandom;
            1: begin
                case ($urandom_range(2))
                    0: return -65536;
                    1: return '0;
                    default: return 65536;
                endcase
            end
            default: return $urandom_range(131072) - 65536;
        endcase
    endfunction

    // stimulus
    initial begin
        rot_sb = new();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        quiet_cycles   = 0;
        i_rst_n        = 1'b0;
        cfg_if.valid   = 1'b0;
        cfg_if.index   = rpa_pkg::REG_ORIGIN_X;
        cfg_if.data    = '0;
        pt_if.valid    = 1'b0;
        pt_if.point_x  = '0;
        pt_if.point_y  = '0;
        pt_if.point_z  = '0;
        res_if.ready   = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: identity rotation, field extremes pass through
        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point(COORD_MAX, COORD_MIN, -1);
        wait_for_results();

        // quarter turn about x with an extreme origin, saturating results
        set_rotation(COORD_MAX, COORD_MIN, '0, 65536, 0, 0, 0, 65536);
        send_point(COORD_MIN, COORD_MAX, COORD_MIN);
        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(1, -1, 1);
        wait_for_results();

        // axis not unit length, cos and sin not matching
        set_rotation('0, '0, '0, 65536, 65536, 65536, -65536, 65536);
        send_point(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000);
        send_point(COORD_MAX, '0, COORD_MIN);
        send_point(-1, -1, -1);
        send_point(12345, -67890, 555);
        wait_for_results();

        // register patterns outside the stated range, junk above the trig width
        set_rotation(COORD_MIN, COORD_MAX, COORD_MIN, 32'h0002_0000, 32'h0001_FFFF,
                     32'hFFFD_FFFF, 32'h0002_0000, 32'hAAAA_5555);
        send_point(COORD_MAX, COORD_MAX, COORD_MAX);
        send_point(COORD_MIN, COORD_MIN, COORD_MIN);
        send_point('0, '0, '0);
        send_point(COORD_MAX, COORD_MIN, '0);
        wait_for_results();

        // degenerate axis and angle, then a negative sine
        set_rotation(32'h7FFF_0000, -5, 1, 0, 0, 0, 0, 0);
        send_point('0, '0, '0);
        send_point(COORD_MIN, COORD_MAX, 1);
        wait_for_results();
        set_rotation(3, -3, 32'h8000_0001, 0, -65536, 0, 65536, -65536);
        send_point(7, -7, 32'sh0000_8000);
        send_point(COORD_MAX, -32'sh0000_8000, COORD_MIN);
        wait_for_results();

        // random settings under each idling pattern
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            for (int n = 0; n < 4; n++) begin
                set_rotation(rand_coord(), rand_coord(), rand_coord(), rand_trig(),
                             rand_trig(), rand_trig(), rand_trig(), rand_trig());
                repeat (28) send_point(rand_coord(), rand_coord(), rand_coord());
                wait_for_results();
            end
        end

        // drain and let the pipe go quiet
        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (rot_sb.errors == 0 && rot_sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
